// File: sv/box_placement_3d_defines.svh
// Assertion macros shared by the checker.
`ifndef BOX_PLACEMENT_3D_DEFINES_SVH
`define BOX_PLACEMENT_3D_DEFINES_SVH

`define BP3_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define BP3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: sv/bp3d_pkg.sv
package bp3d_pkg;

	localparam int unsigned CW = 12;
	localparam int unsigned CNT_W = 7;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MAX_RD,
		S_MAX_ACC,
		S_BOX_RD,
		S_CAND_GEN,
		S_CHK_RD,
		S_CHK_ACC,
		S_CAND_DONE,
		S_WRITE,
		S_OUT
	} state_t;

	localparam logic [1:0] REG_CX = 2'd0;
	localparam logic [1:0] REG_CY = 2'd1;
	localparam logic [1:0] REG_CZ = 2'd2;

endpackage

// File: sv/box_placement_3d.sv
// Box placement engine, bottom-back-left extreme-point rule.
// Input stream s_axis: tuser = request (0 clear, 1 place), tdata = size x,y,z.
// Output stream m_axis: tdata = status, pos x,y,z, box count; one result per request.
// APB port sets container extents (x at 0x0, y at 0x4, z at 0x8).
// The box table lives in one synchronous memory, read one entry at a time.
// A place request with N stored boxes first sweeps the table for the axis
// maxima, then checks the 8 corner candidates and the 3N box candidates (each
// box candidate with one extra read to fetch the box) against every stored
// box, then writes the chosen box, skipping the write when no position is
// found. The result of a clear or a full-table request is valid in the cycle
// after the request transaction.
// Only one request is in flight; s_axis_tready is low until its result is
// taken and rises the cycle after.
// The result holds in the output register while m_axis_tready is low.
// Reset empties the table and sets each container extent to its maximum;
// the memory itself needs no clearing since only entries below the count are read.
module box_placement_3d
	import bp3d_pkg::*;
#(
	parameter int unsigned MAX_BOXES  = 64,
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// size_x, size_y, size_z
	input  logic [((3*COORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
	input  logic                    s_axis_tuser,  // req_type
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// status, pos_x, pos_y, pos_z, box_count
	output logic [((3*COORD_BITS+16)/8)*8-1:0] m_axis_tdata,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [3:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int unsigned CB = COORD_BITS;
	localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int unsigned NW = $clog2(MAX_BOXES + 1);
	localparam int unsigned EW = CB + 3;
	localparam int unsigned ODW = ((3*COORD_BITS+16)/8)*8;

	logic [CB-1:0] cont_q [3];
	state_t state_q, state_d;
	logic [NW-1:0] count_q;
	logic [NW-1:0] idx_q;
	logic [3:0] cand_q;
	logic [NW-1:0] cbox_q;
	logic [1:0] cj_q;
	logic [CB-1:0] sz_q [3];
	logic [CB:0] mx_q [3];
	logic [CB:0] c_q [3];
	logic cok_q, sup_q, found_q;
	logic [CB:0] best_q [3];
	status_t stat_q;
	logic [CB-1:0] opos_q [3];
	logic ovalid_q;

	logic [6*CB-1:0] rdata;
	logic [AW-1:0] raddr;
	logic we;
	logic [CB-1:0] rp [3];
	logic [CB-1:0] rs [3];
	logic [EW-1:0] bend [3];
	logic [EW-1:0] cend [3];
	logic apart, on_top, mid_in;
	logic [EW-1:0] mxx, mzz;
	logic [CB:0] gen [3];
	logic [CB:0] box_c [3];
	logic in_box_cands;
	logic lt_best, take, found_now, last_cand;

	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_CX: prdata[CB-1:0] = cont_q[0];
			REG_CY: prdata[CB-1:0] = cont_q[1];
			REG_CZ: prdata[CB-1:0] = cont_q[2];
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) cont_q[a] <= '1;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_CX: cont_q[0] <= pwdata[CB-1:0];
				REG_CY: cont_q[1] <= pwdata[CB-1:0];
				REG_CZ: cont_q[2] <= pwdata[CB-1:0];
				default: ;
			endcase
		end
	end

	assign raddr = (state_q == S_BOX_RD) ? cbox_q[AW-1:0] : idx_q[AW-1:0];
	assign we = (state_q == S_WRITE);

	bp3d_table #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(CB)) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(count_q[AW-1:0]),
		.wdata({sz_q[2], sz_q[1], sz_q[0],
			best_q[2][CB-1:0], best_q[1][CB-1:0], best_q[0][CB-1:0]}),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			rp[a] = rdata[a*CB +: CB];
			rs[a] = rdata[(3+a)*CB +: CB];
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = ODW'({CNT_W'(count_q), opos_q[2], opos_q[1], opos_q[0], stat_q});

	// candidate check against one stored box
	always_comb begin
		apart = 1'b0;
		for (int a = 0; a < 3; a++) begin
			bend[a] = EW'(rp[a]) + EW'(rs[a]);
			cend[a] = EW'(c_q[a]) + EW'(sz_q[a]);
			if (bend[a] <= EW'(c_q[a]) || cend[a] <= EW'(rp[a])) apart = 1'b1;
		end
		on_top = (bend[1] == EW'(c_q[1]));
		mxx = (EW'(c_q[0]) << 1) + EW'(sz_q[0]);
		mzz = (EW'(c_q[2]) << 1) + EW'(sz_q[2]);
		mid_in = (EW'(rp[0]) << 1) <= mxx && mxx <= (bend[0] << 1)
			&& (EW'(rp[2]) << 1) <= mzz && mzz <= (bend[2] << 1);
	end

	// candidate generation
	assign in_box_cands = cand_q[3];
	always_comb begin
		gen[0] = cand_q[2] ? mx_q[0] : '0;
		gen[1] = cand_q[1] ? mx_q[1] : '0;
		gen[2] = cand_q[0] ? mx_q[2] : '0;
		for (int a = 0; a < 3; a++)
			box_c[a] = (CB+1)'(rp[a]) + ((cj_q == 2'(a)) ? (CB+1)'(rs[a]) : '0);
	end

	always_comb begin
		if (c_q[2] != best_q[2]) lt_best = c_q[2] < best_q[2];
		else if (c_q[1] != best_q[1]) lt_best = c_q[1] < best_q[1];
		else lt_best = c_q[0] < best_q[0];
	end

	always_comb begin
		take = cok_q && (sup_q || c_q[1] == '0)
			&& cend[0] <= EW'(cont_q[0])
			&& cend[1] <= EW'(cont_q[1])
			&& cend[2] <= EW'(cont_q[2])
			&& (!found_q || lt_best);
		found_now = found_q || take;
		if (in_box_cands) last_cand = (cj_q == 2'd2) && (cbox_q + NW'(1) == count_q);
		else last_cand = (cand_q == 4'd7) && (count_q == '0);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (s_axis_tvalid) begin
				if (!s_axis_tuser || count_q >= NW'(MAX_BOXES)) state_d = S_OUT;
				else state_d = S_MAX_RD;
			end
			S_MAX_RD: state_d = (idx_q == count_q) ? S_CAND_GEN : S_MAX_ACC;
			S_MAX_ACC: state_d = S_MAX_RD;
			S_BOX_RD: state_d = S_CAND_GEN;
			S_CAND_GEN: state_d = S_CHK_RD;
			S_CHK_RD: state_d = (idx_q == count_q) ? S_CAND_DONE : S_CHK_ACC;
			S_CHK_ACC: state_d = S_CHK_RD;
			S_CAND_DONE: begin
				if (last_cand) state_d = found_now ? S_WRITE : S_OUT;
				else if (in_box_cands || cand_q == 4'd7) state_d = S_BOX_RD;
				else state_d = S_CAND_GEN;
			end
			S_WRITE: state_d = S_OUT;
			S_OUT: if (ovalid_q && m_axis_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && s_axis_tvalid && !s_axis_tuser) count_q <= '0;
			else if (state_q == S_WRITE) count_q <= count_q + NW'(1);
			if (state_d == S_OUT && state_q != S_OUT) ovalid_q <= 1'b1;
			else if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				for (int a = 0; a < 3; a++) begin
					sz_q[a] <= s_axis_tdata[a*CB +: CB];
					mx_q[a] <= '0;
					best_q[a] <= '0;
					opos_q[a] <= '0;
				end
				found_q <= 1'b0;
				idx_q <= '0;
				cand_q <= '0;
				cbox_q <= '0;
				cj_q <= '0;
				stat_q <= (s_axis_tuser && count_q >= NW'(MAX_BOXES)) ? ST_FULL : ST_OK;
			end
			S_MAX_ACC: begin
				for (int a = 0; a < 3; a++) begin
					if (EW'(rp[a]) + (EW'(rs[a]) << 1) <= EW'(cont_q[a])
						&& bend[a] > EW'(mx_q[a]))
						mx_q[a] <= bend[a][CB:0];
				end
				idx_q <= idx_q + NW'(1);
			end
			S_CAND_GEN: begin
				cok_q <= 1'b1;
				sup_q <= 1'b0;
				idx_q <= '0;
				for (int a = 0; a < 3; a++) c_q[a] <= in_box_cands ? box_c[a] : gen[a];
			end
			S_CHK_ACC: begin
				if (!apart) cok_q <= 1'b0;
				if (on_top && mid_in) sup_q <= 1'b1;
				idx_q <= idx_q + NW'(1);
			end
			S_CAND_DONE: begin
				if (take) begin
					found_q <= 1'b1;
					for (int a = 0; a < 3; a++) best_q[a] <= c_q[a];
				end
				if (last_cand && !found_now) stat_q <= ST_NONE;
				if (!in_box_cands) cand_q <= cand_q + 4'd1;
				else if (cj_q == 2'd2) begin
					cj_q <= '0;
					cbox_q <= cbox_q + NW'(1);
				end else begin
					cj_q <= cj_q + 2'd1;
				end
			end
			S_WRITE: begin
				for (int a = 0; a < 3; a++) opos_q[a] <= best_q[a][CB-1:0];
			end
			default: ;
		endcase
	end

endmodule

// File: sv/bp3d_table.sv
module bp3d_table
	import bp3d_pkg::*;
#(
	parameter int unsigned MAX_BOXES  = 64,
	parameter int unsigned COORD_BITS = 12,
	parameter int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [6*COORD_BITS-1:0]   wdata,
	input  logic [AW-1:0]             raddr,
	output logic [6*COORD_BITS-1:0]   rdata
);

	logic [6*COORD_BITS-1:0] mem [MAX_BOXES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/bp3d_checker.sv
`include "box_placement_3d_defines.svh"
module bp3d_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic pready
);
	`BP3_ASSERT_IMPL(a_no_overlap, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	`BP3_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`BP3_ASSERT_IMPL(a_pready, clk, arst_n, 1'b1, pready)
endmodule

bind box_placement_3d bp3d_checker u_chk (.*);
